// ===== src/iso_week_number_unit_defines.svh =====
// Assertion macros for the ISO week number unit.
`ifndef ISO_WEEK_NUMBER_UNIT_DEFINES_SVH
`define ISO_WEEK_NUMBER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define IWN_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("iwn: check failed");

// A condition that, once seen, must later be followed by another.
`define IWN_ASSERT_LAT4(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##4 (cons)) \
		else $error("iwn: latency check failed");

`else

`define IWN_ASSERT_ALWAYS(label, cond)
`define IWN_ASSERT_LAT4(label, ante, cons)

`endif

`endif

// ===== src/iwn_pkg.sv =====
// Shared types, constants and tables for the ISO week number unit.
`timescale 1ns / 1ps

package iwn_pkg;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic [5:0] week_number;
		logic [2:0] weekday;
		logic [8:0] day_of_year;
		logic       leap_year;
	} result_t;

	// Year sums and flags passed from the year stages to the week stages.
	typedef struct packed {
		logic        valid;
		logic [14:0] sum_date;
		logic [14:0] sum_this;
		logic [14:0] sum_prev;
		logic        leap_this;
		logic        leap_prev;
		logic [8:0]  day_of_year;
	} year_info_t;

	localparam logic [14:0] YEAR_BIAS   = 15'd400;
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int unsigned SHIFT_100   = 19;
	localparam logic [8:0]  RECIP_7     = 9'd293;
	localparam int unsigned SHIFT_7     = 11;
	localparam logic [5:0]  WEEKS_LONG  = 6'd53;
	localparam logic [5:0]  WEEKS_SHORT = 6'd52;
	localparam logic [3:0]  MONTH_MAX   = 4'd12;

	function automatic logic [2:0] month_key(input logic [3:0] mi);
		logic [2:0] k;
		unique case (mi)
			4'd0:    k = 3'd0;
			4'd1:    k = 3'd3;
			4'd2:    k = 3'd2;
			4'd3:    k = 3'd5;
			4'd4:    k = 3'd0;
			4'd5:    k = 3'd3;
			4'd6:    k = 3'd5;
			4'd7:    k = 3'd1;
			4'd8:    k = 3'd4;
			4'd9:    k = 3'd6;
			4'd10:   k = 3'd2;
			default: k = 3'd4;
		endcase
		return k;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] mi);
		logic [8:0] s;
		unique case (mi)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			default: s = 9'd334;
		endcase
		return s;
	endfunction

endpackage

// ===== src/iwn_year_calc.sv =====
// Year arithmetic stages: century quotient, day-count sums, leap flags, ordinal day.
`timescale 1ns / 1ps

module iwn_year_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  iwn_pkg::date_t      date,
	output iwn_pkg::year_info_t info
);

	logic        valid_s1;
	logic [14:0] yb_s1;
	logic [3:0]  mi_s1;
	logic [4:0]  day_s1;
	logic [27:0] prod_s1;

	logic [3:0]  mi_c;
	logic [14:0] yb_c;

	always_comb begin
		if (date.month == 4'd0) begin
			mi_c = 4'd0;
		end else if (date.month > iwn_pkg::MONTH_MAX) begin
			mi_c = iwn_pkg::MONTH_MAX - 4'd1;
		end else begin
			mi_c = date.month - 4'd1;
		end
		yb_c = {1'b0, date.year} + iwn_pkg::YEAR_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		yb_s1   <= yb_c;
		mi_s1   <= mi_c;
		day_s1  <= date.day;
		prod_s1 <= {13'd0, yb_c} * {15'd0, iwn_pkg::RECIP_100};
	end

	// Second stage: quotients for this year and the previous one.
	logic [8:0]  q100;
	logic [8:0]  qb100;
	logic [6:0]  rem100;
	logic [14:0] yb_prev;
	logic [14:0] sum_this;
	logic [14:0] sum_prev;
	logic        leap_this;
	logic        leap_prev;
	logic [14:0] sum_date;
	logic [8:0]  doy;

	always_comb begin
		q100    = prod_s1[27:iwn_pkg::SHIFT_100];
		rem100  = 7'(yb_s1 - ({6'd0, q100} * 15'd100));
		qb100   = q100 - {8'd0, (rem100 == 7'd0)};
		yb_prev = yb_s1 - 15'd1;

		sum_this = yb_s1 + (yb_s1 >> 2) - {6'd0, q100} + {8'd0, q100[8:2]};
		sum_prev = yb_prev + (yb_prev >> 2) - {6'd0, qb100} + {8'd0, qb100[8:2]};

		leap_this = (yb_s1[1:0] == 2'd0) && ((rem100 != 7'd0) || (q100[1:0] == 2'd0));
		leap_prev = (yb_prev[1:0] == 2'd0) && ((rem100 != 7'd1) || (qb100[1:0] == 2'd0));

		// January and February count their weekday from the previous year.
		sum_date = ((mi_s1 < 4'd2) ? sum_prev : sum_this)
			+ {12'd0, iwn_pkg::month_key(mi_s1)} + {10'd0, day_s1};

		doy = {4'd0, day_s1} + iwn_pkg::month_start(mi_s1)
			+ {8'd0, ((mi_s1 >= 4'd2) && leap_this)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info <= '0;
		end else begin
			info.valid       <= valid_s1;
			info.sum_date    <= sum_date;
			info.sum_this    <= sum_this;
			info.sum_prev    <= sum_prev;
			info.leap_this   <= leap_this;
			info.leap_prev   <= leap_prev;
			info.day_of_year <= doy;
		end
	end

endmodule

// ===== src/iwn_week_calc.sv =====
// Week stages: weekday reduction, week count and wrap into neighbouring years.
`timescale 1ns / 1ps

module iwn_week_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  iwn_pkg::year_info_t info,
	output logic                done,
	output iwn_pkg::result_t    result
);

	// Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [14:0] v);
		logic [5:0] f1;
		logic [3:0] f2;
		f1 = {3'd0, v[2:0]} + {3'd0, v[5:3]} + {3'd0, v[8:6]}
			+ {3'd0, v[11:9]} + {3'd0, v[14:12]};
		f2 = {1'b0, f1[2:0]} + {1'b0, f1[5:3]};
		return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
	endfunction

	logic       valid_s3;
	logic [2:0] wd_s3;
	logic [8:0] count_s3;
	logic       long_this_s3;
	logic       long_prev_s3;
	logic [8:0] doy_s3;
	logic       leap_s3;

	logic [2:0] res_date;
	logic [2:0] res_this;
	logic [2:0] res_prev;
	logic [2:0] wd_c;

	always_comb begin
		res_date = mod7(info.sum_date);
		res_this = mod7(info.sum_this);
		res_prev = mod7(info.sum_prev);
		wd_c     = (res_date == 3'd0) ? 3'd7 : res_date;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= info.valid;
		end
	end

	// A year is long when 31 December is a Thursday, or a Friday in a leap year.
	always_ff @(posedge clk) begin
		wd_s3        <= wd_c;
		count_s3     <= info.day_of_year + 9'd10 - {6'd0, wd_c};
		long_this_s3 <= (res_this == 3'd4) || (info.leap_this && (res_this == 3'd5));
		long_prev_s3 <= (res_prev == 3'd4) || (info.leap_prev && (res_prev == 3'd5));
		doy_s3       <= info.day_of_year;
		leap_s3      <= info.leap_this;
	end

	logic [17:0] prod7;
	logic [5:0]  week_raw;
	logic [5:0]  weeks_this;
	logic [5:0]  week_c;

	always_comb begin
		prod7      = {9'd0, count_s3} * {9'd0, iwn_pkg::RECIP_7};
		week_raw   = 6'(prod7 >> iwn_pkg::SHIFT_7);
		weeks_this = long_this_s3 ? iwn_pkg::WEEKS_LONG : iwn_pkg::WEEKS_SHORT;
		priority if (week_raw == 6'd0) begin
			week_c = long_prev_s3 ? iwn_pkg::WEEKS_LONG : iwn_pkg::WEEKS_SHORT;
		end else if (week_raw > weeks_this) begin
			week_c = 6'd1;
		end else begin
			week_c = week_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		result.week_number <= week_c;
		result.weekday     <= wd_s3;
		result.day_of_year <= doy_s3;
		result.leap_year   <= leap_s3;
	end

endmodule

// ===== src/iso_week_number_unit.sv =====
// Top level of the ISO week number unit: a four-stage date decoder.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------
//   date in  | start, busy       | date   (year, month, day)
//   result   | done (one cycle)  | result (week, weekday, ordinal day, leap)
//
// One date is taken in every clock cycle; busy is never raised.
// Each date goes through the four register stages (century quotient
// multiply, year sums, weekday residue, week quotient multiply and wrap).
// Reset clears the valid bits of the stages and the year-stage record; no result
// is shown after reset until a date has gone through. The receiver cannot
// stall, so nothing is held.
`timescale 1ns / 1ps
`include "iso_week_number_unit_defines.svh"

module iso_week_number_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  iwn_pkg::date_t   date,
	output logic             done,
	output iwn_pkg::result_t result
);

	iwn_pkg::year_info_t info;
	logic                accept;
	logic                result_ok;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	iwn_year_calc u_year (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.date     (date),
		.info     (info)
	);

	iwn_week_calc u_week (
		.clk    (clk),
		.arst_n (arst_n),
		.info   (info),
		.done   (done),
		.result (result)
	);

	assign result_ok = (result.weekday != 3'd0) && (result.week_number != 6'd0)
		&& (result.week_number <= iwn_pkg::WEEKS_LONG);

	// Every transfer in leaves exactly one result.
	`IWN_ASSERT_LAT4(a_result_follows, accept, done)
	`IWN_ASSERT_LAT4(a_no_spurious, !accept, !done)
	`IWN_ASSERT_ALWAYS(a_result_range, !done || result_ok)

endmodule
